// File: src/gotm_pkg.sv
// shared constants and types for the greedy task matcher
`default_nettype none
package gotm_pkg;
  localparam int unsigned Depth = 256;
  localparam int unsigned MaxCopies = 8;
  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [47:0] UtilMax = 48'hFFFF_FFFF_FFFF;

  // one table entry as it moves along the chain
  typedef struct packed {
    logic        open;
    logic [31:0] ident;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] rad;
    logic [30:0] start;
    logic [30:0] dur;
    logic [15:0] val;
    logic [31:0] age;
  } entry_t;

  // arriving copy as seen by the scoring pipe
  typedef struct packed {
    logic        isw;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] rad;
    logic [30:0] start;
    logic [30:0] dur;
    logic [15:0] val;
  } probe_t;
endpackage
`default_nettype wire

// File: src/gotm_cell.sv
// one table entry: holds state, shifts along the ring and can be loaded or closed
`default_nettype none
module gotm_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire logic            load_i,
  input  wire gotm_pkg::entry_t load_data_i,
  input  wire logic            close_i,
  input  wire gotm_pkg::entry_t prev_i,
  output gotm_pkg::entry_t     entry_o
);
  gotm_pkg::entry_t entry_q, entry_d;

  // shift in from the neighbor, or load / close when selected (the last ring position)
  always_comb begin
    entry_d = entry_q;
    if (shift_i) entry_d = prev_i;
    if (load_i) entry_d = load_data_i;
    if (close_i) entry_d.open = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
endmodule
`default_nettype wire

// File: src/gotm_score.sv
// scores one table entry against the arriving copy over two register stages
`default_nettype none
module gotm_score (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire gotm_pkg::probe_t probe_i,
  input  wire gotm_pkg::entry_t cand_i,
  input  wire logic [gotm_pkg::IdxW-1:0] pos_i,
  output logic                 vld_o,
  output logic [31:0]          gain_o,
  output logic [31:0]          age_o,
  output logic [gotm_pkg::IdxW-1:0] pos_o
);
  logic        s1_q, ok1_q;
  logic [33:0] dx2_q, dy2_q;
  logic [31:0] r2_q, gain1_q, age1_q;
  logic [gotm_pkg::IdxW-1:0] pos1_q;
  logic [31:0] ws, we, ts, te;
  logic [15:0] wx, wy, tx, ty, rr;
  logic signed [16:0] dx, dy;

  // roles of the probe and the stored entry
  always_comb begin
    if (probe_i.isw) begin
      wx = probe_i.px; wy = probe_i.py; rr = probe_i.rad;
      ws = {1'b0, probe_i.start}; we = {1'b0, probe_i.start} + {1'b0, probe_i.dur};
      tx = cand_i.px; ty = cand_i.py;
      ts = {1'b0, cand_i.start}; te = {1'b0, cand_i.start} + {1'b0, cand_i.dur};
    end else begin
      wx = cand_i.px; wy = cand_i.py; rr = cand_i.rad;
      ws = {1'b0, cand_i.start}; we = {1'b0, cand_i.start} + {1'b0, cand_i.dur};
      tx = probe_i.px; ty = probe_i.py;
      ts = {1'b0, probe_i.start}; te = {1'b0, probe_i.start} + {1'b0, probe_i.dur};
    end
    dx = $signed({wx[15], wx}) - $signed({tx[15], tx});
    dy = $signed({wy[15], wy}) - $signed({ty[15], ty});
  end

  // stage one: squares, window test and gain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else begin
      s1_q <= en_i && cand_i.open;
    end
  end

  always_ff @(posedge clk_i) begin
    ok1_q   <= (ws < te) && (ts < we);
    dx2_q   <= 34'(dx * dx);
    dy2_q   <= 34'(dy * dy);
    r2_q    <= rr * rr;
    gain1_q <= cand_i.val * probe_i.val;
    age1_q  <= cand_i.age;
    pos1_q  <= pos_i;
  end

  // stage two: distance compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= s1_q && ok1_q && ((35'(dx2_q) + 35'(dy2_q)) <= 35'(r2_q))
               && (gain1_q != 32'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    gain_o <= gain1_q;
    age_o  <= age1_q;
    pos_o  <= pos1_q;
  end
endmodule
`default_nettype wire

// File: src/greedy_online_task_matcher.sv
// top level of the greedy online task matcher
// Each input word expands into one to eight copies (workers by capacity, tasks one).
// Each copy first walks its own table, one entry per cycle, to find the lowest free
// slot, then walks the opposite table the same way to score candidates. A paired
// copy then rotates both tables once more to close both entries, and a copy dropped
// on a full table skips the scoring walk. The two tables are rings of cells that
// rotate one position per cycle while a walk runs, and one full rotation returns
// every entry to its home slot.
// Results carry the pair, the gain and the running totals; a new word is taken
// only after its last result has left.
`default_nettype none
module greedy_online_task_matcher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        is_worker_i,
  input  wire logic [31:0] entity_id_i,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  input  wire logic [15:0] reach_i,
  input  wire logic [3:0]  copies_i,
  input  wire logic [30:0] start_time_i,
  input  wire logic [30:0] duration_i,
  input  wire logic [15:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             matched_o,
  output logic             stored_ok_o,
  output logic [31:0]      task_ident_o,
  output logic [31:0]      worker_ident_o,
  output logic [31:0]      gain_o,
  output logic [47:0]      total_utility_o,
  output logic [31:0]      match_total_o,
  output logic             last_o
);
  localparam int unsigned D = gotm_pkg::Depth;
  localparam int unsigned IW = gotm_pkg::IdxW;
  localparam int unsigned CW = gotm_pkg::CntW;
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StFree = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StFix = 3'd4;
  localparam logic [2:0] StOut = 3'd5;

  logic [2:0] st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [3:0] left_q, left_d;
  logic [2:0] drain_q, drain_d;
  logic isw_q, found_q, found_d, have_q, have_d;
  logic [31:0] id_q;
  gotm_pkg::probe_t pr_q;
  logic [IW-1:0] slot_q, slot_d, best_q, best_d;
  logic [31:0] bgain_q, bgain_d, bage_q, bage_d, arr_q, arr_d, pairs_q, pairs_d;
  logic [47:0] util_q, util_d;
  logic [31:0] pid_q, pid_d;

  gotm_pkg::entry_t wk [D];
  gotm_pkg::entry_t tk [D];
  logic wshift, tshift, wload, tload, wclose, tclose;
  gotm_pkg::entry_t newent;
  logic [IW-1:0] pos;

  // worker and task rings; head is position 0, rotation moves entry i to i-1
  // load and close act on the entry leaving the head, which lands in the last cell
  for (genvar g = 0; g < D; g++) begin : g_ring
    gotm_cell u_w (
      .clk_i, .rst_ni, .shift_i(wshift),
      .load_i(wload && g == D - 1), .load_data_i(newent),
      .close_i(wclose && g == D - 1), .prev_i(wk[(g + 1) % D]), .entry_o(wk[g]));
    gotm_cell u_t (
      .clk_i, .rst_ni, .shift_i(tshift),
      .load_i(tload && g == D - 1), .load_data_i(newent),
      .close_i(tclose && g == D - 1), .prev_i(tk[(g + 1) % D]), .entry_o(tk[g]));
  end

  assign pos = cnt_q[IW-1:0];

  // scoring pipe on the head of the opposite ring
  logic sv;
  logic [31:0] sg, sa;
  logic [IW-1:0] sp;
  gotm_score u_score (
    .clk_i, .rst_ni, .en_i(st_q == StScan), .probe_i(pr_q),
    .cand_i(isw_q ? tk[0] : wk[0]), .pos_i(pos),
    .vld_o(sv), .gain_o(sg), .age_o(sa), .pos_o(sp));

  always_comb begin
    newent.open  = 1'b1;
    newent.ident = id_q;
    newent.px    = pr_q.px;
    newent.py    = pr_q.py;
    newent.rad   = pr_q.rad;
    newent.start = pr_q.start;
    newent.dur   = pr_q.dur;
    newent.val   = pr_q.val;
    newent.age   = arr_q;
  end

  function automatic logic [47:0] UtilMaxDiff(input logic [47:0] u);
    return gotm_pkg::UtilMax - u;
  endfunction

  // sequencer
  always_comb begin
    st_d = st_q; cnt_d = cnt_q; left_d = left_q; drain_d = drain_q;
    found_d = found_q; have_d = have_q; slot_d = slot_q; best_d = best_q;
    bgain_d = bgain_q; bage_d = bage_q; arr_d = arr_q; pairs_d = pairs_q;
    util_d = util_q; pid_d = pid_q;
    wshift = 1'b0; tshift = 1'b0; wload = 1'b0; tload = 1'b0;
    wclose = 1'b0; tclose = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          st_d = StFree; cnt_d = '0; have_d = 1'b0;
          if (!is_worker_i || copies_i == 4'd0) left_d = 4'd1;
          else if (copies_i > 4'(gotm_pkg::MaxCopies)) left_d = 4'(gotm_pkg::MaxCopies);
          else left_d = copies_i;
        end
      end
      StFree: begin
        // rotate own ring once; store at the first free slot on the way
        if (!have_q && !(isw_q ? wk[0].open : tk[0].open)) begin
          have_d = 1'b1; slot_d = pos;
          if (isw_q) wload = 1'b1; else tload = 1'b1;
          arr_d = arr_q + 32'd1;
        end
        if (isw_q) wshift = 1'b1; else tshift = 1'b1;
        cnt_d = cnt_q + 1'b1;
        found_d = 1'b0;
        if (cnt_q == CW'(D - 1)) begin
          cnt_d = '0;
          st_d = (have_d) ? StScan : StOut;
        end
      end
      StScan: begin
        if (isw_q) tshift = 1'b1; else wshift = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(D - 1)) begin
          cnt_d = '0; st_d = StDrain; drain_d = 3'd0;
        end
      end
      StDrain: begin
        drain_d = drain_q + 3'd1;
        if (drain_q == 3'd2) begin
          st_d = found_q ? StFix : StOut; cnt_d = '0;
        end
      end
      StFix: begin
        // rotate both rings once, closing the pair as each passes the head
        wshift = 1'b1; tshift = 1'b1;
        if (pos == slot_q) begin
          if (isw_q) wclose = 1'b1; else tclose = 1'b1;
        end
        if (pos == best_q) begin
          if (isw_q) begin tclose = 1'b1; pid_d = tk[0].ident; end
          else begin wclose = 1'b1; pid_d = wk[0].ident; end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(D - 1)) begin
          cnt_d = '0; st_d = StOut;
          pairs_d = pairs_q + 32'd1;
          util_d = (UtilMaxDiff(util_q) < {16'd0, bgain_q}) ? gotm_pkg::UtilMax
                   : util_q + {16'd0, bgain_q};
        end
      end
      StOut: begin
        if (out_ready_i) begin
          left_d = left_q - 4'd1; have_d = 1'b0; cnt_d = '0;
          st_d = (left_q == 4'd1) ? StIdle : StFree;
        end
      end
      default: st_d = StIdle;
    endcase
    // collect scores arriving from the pipe
    if (sv && (!found_q || sg > bgain_q || (sg == bgain_q && sa < bage_q))) begin
      found_d = 1'b1; bgain_d = sg; bage_d = sa; best_d = sp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; left_q <= '0; drain_q <= '0;
      found_q <= 1'b0; have_q <= 1'b0; arr_q <= '0; pairs_q <= '0; util_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; left_q <= left_d; drain_q <= drain_d;
      found_q <= found_d; have_q <= have_d; arr_q <= arr_d;
      pairs_q <= pairs_d; util_q <= util_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d; best_q <= best_d; bgain_q <= bgain_d; bage_q <= bage_d;
    pid_q <= pid_d;
    if (st_q == StIdle && in_valid_i) begin
      isw_q <= is_worker_i; id_q <= entity_id_i;
      pr_q.isw <= is_worker_i; pr_q.px <= pos_x_i; pr_q.py <= pos_y_i;
      pr_q.rad <= reach_i; pr_q.start <= start_time_i; pr_q.dur <= duration_i;
      pr_q.val <= value_i;
    end
  end

  // result word
  assign in_ready_o      = (st_q == StIdle);
  assign out_valid_o     = (st_q == StOut);
  assign matched_o       = found_q;
  assign stored_ok_o     = have_q;
  assign task_ident_o    = isw_q ? (found_q ? pid_q : 32'd0) : id_q;
  assign worker_ident_o  = isw_q ? id_q : (found_q ? pid_q : 32'd0);
  assign gain_o          = found_q ? bgain_q : 32'd0;
  assign total_utility_o = util_q;
  assign match_total_o   = pairs_q;
  assign last_o          = (left_q == 4'd1);
endmodule
`default_nettype wire

// File: src/gotm_checker.sv
// port-level checks on the matcher, bound to the top level
`default_nettype none
module gotm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        matched_o,
  input wire logic        stored_ok_o,
  input wire logic [31:0] gain_o,
  input wire logic [31:0] match_total_o
);
  // never ready while a result is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready with pending result");
  // a match implies a stored copy and nonzero gain
  a_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && matched_o |-> stored_ok_o && gain_o != 32'd0)
    else $error("match without store or gain");
  // unmatched results carry zero gain
  a_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !matched_o |-> gain_o == 32'd0) else $error("gain on no match");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_total_o))
    else $error("stalled result changed");
endmodule

bind greedy_online_task_matcher gotm_checker u_gotm_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .matched_o,
  .stored_ok_o, .gain_o, .match_total_o);
`default_nettype wire

// File: tb/sv/gotm_checker.sv
// scoreboard for the greedy task matcher: predicts every result word and compares it
`default_nettype none
module gotm_scoreboard (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic        is_worker_i,
  input  wire logic [31:0] entity_id_i,
  input  wire logic [15:0] pos_x_i,
  input  wire logic [15:0] pos_y_i,
  input  wire logic [15:0] reach_i,
  input  wire logic [3:0]  copies_i,
  input  wire logic [30:0] start_time_i,
  input  wire logic [30:0] duration_i,
  input  wire logic [15:0] value_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic        matched_i,
  input  wire logic        stored_ok_i,
  input  wire logic [31:0] task_ident_i,
  input  wire logic [31:0] worker_ident_i,
  input  wire logic [31:0] gain_i,
  input  wire logic [47:0] total_utility_i,
  input  wire logic [31:0] match_total_i,
  input  wire logic        last_i,
  output int unsigned      mismatch_o,
  output int unsigned      pending_o,
  output int unsigned      words_seen_o,
  output int unsigned      pairs_seen_o,
  output int unsigned      drops_seen_o
);

  // one predicted result word
  typedef struct {
    bit        matched;
    bit        stored;
    bit [31:0] task_id;
    bit [31:0] worker_id;
    bit [31:0] gain;
    bit [47:0] utility;
    bit [31:0] pairs;
    bit        last;
  } pairing_t;

  pairing_t  pairing_q[$];
  gotm_pkg::entry_t worker_tab[gotm_pkg::Depth];
  gotm_pkg::entry_t task_tab[gotm_pkg::Depth];
  bit [47:0] utility_acc = '0;
  bit [31:0] pair_acc = '0;
  bit [31:0] arrival_acc = '0;

  initial begin
    mismatch_o = 0;
    pending_o = 0;
    words_seen_o = 0;
    pairs_seen_o = 0;
    drops_seen_o = 0;
    for (int i = 0; i < gotm_pkg::Depth; i++) begin
      worker_tab[i] = '0;
      task_tab[i] = '0;
    end
  end

  // strict window overlap and squared distance within the worker radius
  function automatic bit in_reach(gotm_pkg::entry_t w, gotm_pkg::entry_t t);
    logic [31:0] ws, we, ts, te;
    longint dx, dy;
    longint unsigned d2, r2;
    ws = {1'b0, w.start};
    we = ws + {1'b0, w.dur};
    ts = {1'b0, t.start};
    te = ts + {1'b0, t.dur};
    if (!(ws < te && ts < we)) return 1'b0;
    dx = longint'($signed(w.px)) - longint'($signed(t.px));
    dy = longint'($signed(w.py)) - longint'($signed(t.py));
    d2 = longint'(dx * dx) + longint'(dy * dy);
    r2 = longint'(w.rad) * longint'(w.rad);
    return d2 <= r2;
  endfunction

  // expand one arrival into its copies and queue the expected words
  task automatic predict_pairings();
    int unsigned n, slot, best;
    bit          isw, stored, found;
    gotm_pkg::entry_t arrival, cand;
    logic [31:0] g, best_gain, best_age;
    pairing_t    p;
    isw = is_worker_i;
    n = copies_i;
    if (!isw || n == 0) n = 1;
    if (n > gotm_pkg::MaxCopies) n = gotm_pkg::MaxCopies;
    for (int k = 0; k < n; k++) begin
      stored = 1'b0;
      found = 1'b0;
      slot = 0;
      best = 0;
      best_gain = '0;
      best_age = '0;
      for (int i = 0; i < gotm_pkg::Depth; i++) begin
        if (!(isw ? worker_tab[i].open : task_tab[i].open)) begin
          slot = i;
          stored = 1'b1;
          break;
        end
      end
      if (stored) begin
        arrival = '{open: 1'b1, ident: entity_id_i, px: pos_x_i, py: pos_y_i,
                    rad: reach_i, start: start_time_i, dur: duration_i,
                    val: value_i, age: arrival_acc};
        arrival_acc = arrival_acc + 1;
        if (isw) worker_tab[slot] = arrival;
        else task_tab[slot] = arrival;
        // best gain over the opposite table, earliest arrival on ties
        for (int i = 0; i < gotm_pkg::Depth; i++) begin
          cand = isw ? task_tab[i] : worker_tab[i];
          if (!cand.open) continue;
          if (!(isw ? in_reach(arrival, cand) : in_reach(cand, arrival))) continue;
          g = cand.val * value_i;
          if (g == 0) continue;
          if (!found || g > best_gain || (g == best_gain && cand.age < best_age)) begin
            found = 1'b1;
            best = i;
            best_gain = g;
            best_age = cand.age;
          end
        end
      end
      p.matched = found;
      p.stored = stored;
      p.task_id = isw ? 32'd0 : entity_id_i;
      p.worker_id = isw ? entity_id_i : 32'd0;
      p.gain = '0;
      if (found) begin
        if (isw) begin
          worker_tab[slot].open = 1'b0;
          task_tab[best].open = 1'b0;
          p.task_id = task_tab[best].ident;
        end else begin
          task_tab[slot].open = 1'b0;
          worker_tab[best].open = 1'b0;
          p.worker_id = worker_tab[best].ident;
        end
        if (gotm_pkg::UtilMax - utility_acc < {16'd0, best_gain})
          utility_acc = gotm_pkg::UtilMax;
        else utility_acc = utility_acc + best_gain;
        pair_acc = pair_acc + 1;
        p.gain = best_gain;
      end
      p.utility = utility_acc;
      p.pairs = pair_acc;
      p.last = (k + 1 == n);
      pairing_q = {pairing_q, p};
    end
  endtask

  task automatic flag_field(string field, longint unsigned want, longint unsigned got);
    mismatch_o++;
    if (mismatch_o <= 10)
      $display("mismatch on word %0d, %s: expected %0h, got %0h",
               words_seen_o, field, want, got);
  endtask

  // arrivals first, then the word leaving at the same edge
  always @(posedge clk_i) begin
    pairing_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) predict_pairings();
      if (out_valid_i && out_ready_i) begin
        if (pairing_q.size() == 0) begin
          mismatch_o++;
          if (mismatch_o <= 10) $display("result word with nothing expected");
        end else begin
          want = pairing_q.pop_front();
          if (matched_i !== want.matched) flag_field("matched", want.matched, matched_i);
          if (stored_ok_i !== want.stored) flag_field("stored_ok", want.stored, stored_ok_i);
          if (task_ident_i !== want.task_id)
            flag_field("task_ident", want.task_id, task_ident_i);
          if (worker_ident_i !== want.worker_id)
            flag_field("worker_ident", want.worker_id, worker_ident_i);
          if (gain_i !== want.gain) flag_field("gain", want.gain, gain_i);
          if (total_utility_i !== want.utility)
            flag_field("total_utility", want.utility, total_utility_i);
          if (match_total_i !== want.pairs)
            flag_field("match_total", want.pairs, match_total_i);
          if (last_i !== want.last) flag_field("last", want.last, last_i);
          if (want.matched) pairs_seen_o++;
          if (!want.stored) drops_seen_o++;
        end
        words_seen_o++;
      end
      pending_o = pairing_q.size();
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// testbench top for the greedy task matcher: clock, reset, stimulus and verdict
`default_nettype none
module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        is_worker_i = 1'b0;
  logic [31:0] entity_id_i = '0;
  logic [15:0] pos_x_i = '0;
  logic [15:0] pos_y_i = '0;
  logic [15:0] reach_i = '0;
  logic [3:0]  copies_i = '0;
  logic [30:0] start_time_i = '0;
  logic [30:0] duration_i = '0;
  logic [15:0] value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        matched_o;
  logic        stored_ok_o;
  logic [31:0] task_ident_o;
  logic [31:0] worker_ident_o;
  logic [31:0] gain_o;
  logic [47:0] total_utility_o;
  logic [31:0] match_total_o;
  logic        last_o;

  int unsigned mismatch_cnt, pending_cnt, words_cnt, pairs_cnt, drops_cnt;
  bit          hold_req = 1'b0;
  bit [30:0]   now_t = '0;
  int unsigned arrivals_sent = 0;

  always #10 clk_i = ~clk_i;

  greedy_online_task_matcher u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .is_worker_i, .entity_id_i,
    .pos_x_i, .pos_y_i, .reach_i, .copies_i, .start_time_i, .duration_i, .value_i,
    .out_valid_o, .out_ready_i, .matched_o, .stored_ok_o, .task_ident_o,
    .worker_ident_o, .gain_o, .total_utility_o, .match_total_o, .last_o
  );

  gotm_scoreboard u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .is_worker_i, .entity_id_i,
    .pos_x_i, .pos_y_i, .reach_i, .copies_i, .start_time_i, .duration_i, .value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .matched_i(matched_o),
    .stored_ok_i(stored_ok_o), .task_ident_i(task_ident_o),
    .worker_ident_i(worker_ident_o), .gain_i(gain_o),
    .total_utility_i(total_utility_o), .match_total_i(match_total_o), .last_i(last_o),
    .mismatch_o(mismatch_cnt), .pending_o(pending_cnt), .words_seen_o(words_cnt),
    .pairs_seen_o(pairs_cnt), .drops_seen_o(drops_cnt)
  );

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // offer one arrival word and hold it until taken
  task automatic offer(bit isw, logic [31:0] id, logic [15:0] x, logic [15:0] y,
                       logic [15:0] rad, logic [3:0] n, logic [30:0] st,
                       logic [30:0] dur, logic [15:0] val);
    int unsigned gap;
    in_valid_i <= 1'b1;
    is_worker_i <= isw;
    entity_id_i <= id;
    pos_x_i <= x;
    pos_y_i <= y;
    reach_i <= rad;
    copies_i <= n;
    start_time_i <= st;
    duration_i <= dur;
    value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    arrivals_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] pick_coord();
    if ($urandom_range(0, 9) < 8) return 16'($signed($urandom_range(0, 600)) - 300);
    return 16'($urandom);
  endfunction

  // result side: bursts of ready, short and long stalls, one long hold-off
  initial begin
    int unsigned r, len;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_req = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_ready_i <= 1'b1;
        len = $urandom_range(1, 20);
      end else if (r < 92) begin
        out_ready_i <= 1'b0;
        len = $urandom_range(1, 3);
      end else begin
        out_ready_i <= 1'b0;
        len = $urandom_range(10, 60);
      end
      repeat (len) @(posedge clk_i);
    end
  end

  initial begin
    #100_000_000;
    $display("timeout with %0d result words still expected", pending_cnt);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    bit          isw;
    logic [15:0] x, y, rad, val;
    logic [3:0]  n;
    logic [30:0] dur, step;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: lone task, radius boundary, zero gain, empty window, extremes
    offer(0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 100, 16'h0100);
    offer(1, 32'h0, 3, 4, 5, 1, 0, 100, 16'h0200);
    offer(0, 11, 16'h8000, 16'h7FFF, 0, 15, 5, 50, 16'h0000);
    offer(1, 12, 16'h8000, 16'h7FFF, 16'hFFFF, 2, 5, 50, 16'hFFFF);
    offer(0, 13, 16'h8000, 16'h7FFF, 0, 0, 6, 0, 16'hFFFF);
    offer(0, 14, 16'h7FFF, 16'h8000, 0, 1, 6, 31'h7FFF_FFFF, 16'h0001);
    // equal gains go to the earlier task, third copy stays alone
    offer(0, 20, 100, 100, 0, 1, 10, 1000, 16'h0080);
    offer(0, 21, 100, 100, 0, 1, 10, 1000, 16'h0080);
    offer(1, 22, 100, 100, 0, 3, 10, 1000, 16'h0100);
    // windows that only touch never pair
    offer(1, 23, 500, 500, 10, 1, 60, 40, 16'h0001);
    offer(0, 24, 500, 500, 0, 1, 100, 10, 16'h0005);
    // zero capacity counts as one, oversized capacity is clamped
    offer(1, 25, 500, 500, 10, 0, 100, 10, 16'h0003);
    offer(1, 26, 16'h7FFF, 16'h7FFF, 16'hFFFF, 15, 100, 31'h7FFF_FFFF, 16'hFFFF);
    // fill the worker table with origin workers until copies are dropped
    for (int i = 0; i < 34; i++)
      offer(1, 32'h1000 + i, 0, 0, 0, 8, 100, 31'h7FFF_FFFF, 16'h0001);
    now_t = 100;

    // random arrivals; origin tasks drain the filler workers
    for (int i = 0; i < 100; i++) begin
      if (i == 40) hold_req = 1'b1;
      step = ($urandom_range(0, 19) == 0) ? 31'($urandom_range(0, 1 << 24))
                                           : 31'($urandom_range(0, 30));
      if (i >= 90) step = 31'h7FFF_FF00 - now_t + 31'($urandom_range(0, 20));
      if (31'h7FFF_FFFF - now_t < step) now_t = 31'h7FFF_FFFF;
      else now_t = now_t + step;
      isw = $urandom_range(0, 1);
      x = pick_coord();
      y = pick_coord();
      rad = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 400)) : 16'($urandom);
      n = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(0, 15));
      dur = ($urandom_range(0, 9) < 8) ? 31'($urandom_range(0, 2000)) : 31'($urandom);
      val = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1) * 16'hFFFF)
                                        : 16'($urandom);
      if (!isw && $urandom_range(0, 9) < 3) begin
        x = '0;
        y = '0;
        if (val == 0) val = 16'h0001;
      end
      offer(isw, $urandom, x, y, rad, n, now_t, dur, val);
    end
    in_valid_i <= 1'b0;

    // let the scoreboard see the last arrival before waiting on it
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);

    $display("%0d arrivals in, %0d result words checked", arrivals_sent, words_cnt);
    $display("%0d pairs made, %0d copies dropped on a full table", pairs_cnt, drops_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d words never seen", mismatch_cnt, pending_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
